// ----- design/fdc_pkg.sv -----
// ----------------------------------------------------------------------------
// fdc_pkg
// Shared types, constants and the CRC-16-CCITT byte step for the frame
// deframer.
// ----------------------------------------------------------------------------
package fdc_pkg;

  localparam int unsigned MaxPayload = 256;
  localparam int unsigned AddrW      = 4;

  localparam logic [15:0] CrcInit    = 16'hFFFF;
  localparam logic [16:0] TickMax    = 17'h1FFFF;

  localparam logic [15:0] PreambleRst = 16'd0;
  localparam logic [8:0]  MaxLenRst   = 9'd256;
  localparam logic [15:0] TimeoutRst  = 16'd1000;

  // register index, taken from paddr[3:2]
  localparam logic [1:0] RegPreamble = 2'd0;
  localparam logic [1:0] RegMaxLen   = 2'd1;
  localparam logic [1:0] RegTimeout  = 2'd2;

  localparam logic CmdByte = 1'b0;
  localparam logic CmdTick = 1'b1;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_LEN   = 3'd1,
    PH_OPC   = 3'd2,
    PH_SRC   = 3'd3,
    PH_DST   = 3'd4,
    PH_CRC   = 3'd5,
    PH_DATA  = 3'd6,
    PH_READY = 3'd7
  } phase_e;

  typedef struct packed {
    logic [2:0] phase;
    logic       payload_valid;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_done;
    logic       crc_ok;
    logic [8:0] frame_length;
    logic [7:0] frame_opcode;
    logic [7:0] frame_source;
    logic [7:0] frame_dest;
    logic       timed_out;
  } result_t;

  // One byte of CRC-16-CCITT, poly 0x1021, MSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [7:0] x;
    x = crc[15:8] ^ b;
    x = x ^ {4'b0, x[7:4]};
    return {crc[7:0], 8'b0} ^ {x[3:0], 12'b0} ^ {3'b0, x, 5'b0} ^ {8'b0, x};
  endfunction

endpackage

// ----- design/frame_deframer_crc16_check.sv -----
// ----------------------------------------------------------------------------
// frame_deframer_crc16_check
// Preamble/length framed byte deframer with streamed payload and
// CRC-16-CCITT check.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while the skid entry is empty; each byte
// item takes its CRC byte step and phase move, where the phase calls for them,
// in the cycle it is accepted, then lands in the output register (a skid entry
// absorbs one item while the output is stalled; input is held off while full).
// Reset (rst_ni low, async): hunting, CRC 0xFFFF, counters and header clear,
// registers at preamble 0, max length 256, timeout 1000.
module frame_deframer_crc16_check import fdc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  // input items
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 command_i,
  input  logic [7:0]           in_byte_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           phase_o,
  output logic                 payload_valid_o,
  output logic [7:0]           payload_byte_o,
  output logic [7:0]           payload_index_o,
  output logic                 frame_done_o,
  output logic                 crc_ok_o,
  output logic [8:0]           frame_length_o,
  output logic [7:0]           frame_opcode_o,
  output logic [7:0]           frame_source_o,
  output logic [7:0]           frame_dest_o,
  output logic                 timed_out_o
);

  // configuration registers
  logic [15:0] preamble_q;
  logic [8:0]  max_len_q;
  logic [15:0] timeout_q;

  // parser state
  phase_e      phase_q, phase_d;
  logic        second_q, second_d;
  logic [8:0]  len_q, len_d;
  logic [7:0]  opc_q, opc_d;
  logic [7:0]  src_q, src_d;
  logic [7:0]  dst_q, dst_d;
  logic [15:0] rx_crc_q, rx_crc_d;
  logic [15:0] crc_q, crc_d;
  logic [8:0]  count_q, count_d;
  logic [16:0] ticks_q, ticks_d;

  // output register and skid entry
  logic        out_valid_q, skid_valid_q;
  result_t     out_q, skid_q, res;

  logic        in_xfer, out_xfer, cfg_wr;
  logic [15:0] len_full;
  logic [8:0]  count_inc;
  logic [2:0]  shown;
  logic        pv, done, tmo;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      RegPreamble: prdata = {16'b0, preamble_q};
      RegMaxLen:   prdata = {23'b0, max_len_q};
      RegTimeout:  prdata = {16'b0, timeout_q};
      default:     prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preamble_q <= PreambleRst;
      max_len_q  <= MaxLenRst;
      timeout_q  <= TimeoutRst;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        RegPreamble: preamble_q <= pwdata[15:0];
        RegMaxLen:   max_len_q  <= pwdata[8:0];
        RegTimeout:  timeout_q  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o  = !skid_valid_q;
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_q && out_ready_i;

  assign len_full    = {in_byte_i, len_q[7:0]};
  assign count_inc   = count_q + 9'd1;

  always_comb begin
    phase_d  = phase_q;
    second_d = second_q;
    len_d    = len_q;
    opc_d    = opc_q;
    src_d    = src_q;
    dst_d    = dst_q;
    rx_crc_d = rx_crc_q;
    crc_d    = crc_q;
    count_d  = count_q;
    ticks_d  = ticks_q;
    pv       = 1'b0;
    done     = 1'b0;
    tmo      = 1'b0;
    shown    = phase_q;

    if (command_i == CmdTick) begin
      if (ticks_q != TickMax) ticks_d = ticks_q + 17'd1;
    end else begin
      case (phase_q)
        PH_HUNT: begin
          ticks_d = 17'd0;
          if (!second_q) begin
            if (in_byte_i == preamble_q[7:0]) begin
              crc_d    = crc_feed(CrcInit, in_byte_i);
              second_d = 1'b1;
            end
          end else begin
            // mismatch drops straight back, this byte is not a first byte
            second_d = 1'b0;
            if (in_byte_i == preamble_q[15:8]) begin
              crc_d   = crc_feed(crc_q, in_byte_i);
              count_d = 9'd0;
              phase_d = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          crc_d = crc_feed(crc_q, in_byte_i);
          if (!second_q) begin
            len_d    = {1'b0, in_byte_i};
            second_d = 1'b1;
          end else begin
            second_d = 1'b0;
            len_d    = len_full[8:0];
            if (len_full <= {7'b0, max_len_q} && len_full <= 16'(MaxPayload))
              phase_d = PH_OPC;
            else
              phase_d = PH_HUNT;
          end
        end
        PH_OPC: begin
          crc_d   = crc_feed(crc_q, in_byte_i);
          opc_d   = in_byte_i;
          phase_d = PH_SRC;
        end
        PH_SRC: begin
          crc_d   = crc_feed(crc_q, in_byte_i);
          src_d   = in_byte_i;
          phase_d = PH_DST;
        end
        PH_DST: begin
          crc_d   = crc_feed(crc_q, in_byte_i);
          dst_d   = in_byte_i;
          phase_d = PH_CRC;
        end
        PH_CRC: begin
          // CRC field counts as zero bytes
          crc_d = crc_feed(crc_q, 8'h00);
          if (!second_q) begin
            rx_crc_d = {8'b0, in_byte_i};
            second_d = 1'b1;
          end else begin
            second_d = 1'b0;
            rx_crc_d = {in_byte_i, rx_crc_q[7:0]};
            phase_d  = (len_q == 9'd0) ? PH_READY : PH_DATA;
          end
        end
        PH_DATA: begin
          crc_d   = crc_feed(crc_q, in_byte_i);
          pv      = 1'b1;
          count_d = count_inc;
          if (count_inc >= len_q) begin
            count_d = 9'd0;
            phase_d = PH_READY;
          end
        end
        default: begin
          phase_d  = PH_HUNT;
          second_d = 1'b0;
        end
      endcase

      if (ticks_d > {1'b0, timeout_q}) begin
        phase_d  = PH_HUNT;
        second_d = 1'b0;
        tmo      = 1'b1;
      end

      shown = phase_d;
      if (phase_d == PH_READY) begin
        done     = 1'b1;
        phase_d  = PH_HUNT;
        second_d = 1'b0;
      end
    end
  end

  always_comb begin
    res.phase         = shown;
    res.payload_valid = pv;
    res.payload_byte  = pv ? in_byte_i : 8'b0;
    res.payload_index = pv ? count_q[7:0] : 8'b0;
    res.frame_done    = done;
    res.crc_ok        = done && (rx_crc_d == crc_d);
    res.frame_length  = done ? len_d : 9'b0;
    res.frame_opcode  = done ? opc_d : 8'b0;
    res.frame_source  = done ? src_d : 8'b0;
    res.frame_dest    = done ? dst_d : 8'b0;
    res.timed_out     = tmo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      second_q <= 1'b0;
      len_q    <= 9'd0;
      opc_q    <= 8'd0;
      src_q    <= 8'd0;
      dst_q    <= 8'd0;
      rx_crc_q <= 16'd0;
      crc_q    <= CrcInit;
      count_q  <= 9'd0;
      ticks_q  <= 17'd0;
    end else if (in_xfer) begin
      phase_q  <= phase_d;
      second_q <= second_d;
      len_q    <= len_d;
      opc_q    <= opc_d;
      src_q    <= src_d;
      dst_q    <= dst_d;
      rx_crc_q <= rx_crc_d;
      crc_q    <= crc_d;
      count_q  <= count_d;
      ticks_q  <= ticks_d;
    end
  end

  // output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_xfer) begin
        out_valid_q  <= skid_valid_q || in_xfer;
        skid_valid_q <= 1'b0;
      end else if (in_xfer) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_xfer) begin
      out_q <= skid_valid_q ? skid_q : res;
    end
    if (in_xfer && out_valid_q && !out_xfer) begin
      skid_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign phase_o         = out_q.phase;
  assign payload_valid_o = out_q.payload_valid;
  assign payload_byte_o  = out_q.payload_byte;
  assign payload_index_o = out_q.payload_index;
  assign frame_done_o    = out_q.frame_done;
  assign crc_ok_o        = out_q.crc_ok;
  assign frame_length_o  = out_q.frame_length;
  assign frame_opcode_o  = out_q.frame_opcode;
  assign frame_source_o  = out_q.frame_source;
  assign frame_dest_o    = out_q.frame_dest;
  assign timed_out_o     = out_q.timed_out;

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the frame deframer. Builds framed byte streams with
// random headers, payloads, CRC faults and interleaved ticks, predicts every
// result with its own parser and CRC, and checks each output transfer in
// order. Both handshake sides idle at random; registers change between runs.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fdc_pkg::*;

  localparam logic [15:0] CcittPoly  = 16'h1021;
  localparam int unsigned QuietLimit = 5000;
  localparam int unsigned RoundItems = 50;
  localparam int unsigned FullFrame  = 32'hFFFF_FFFF;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [31:0]      pwdata;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             command_i;
  logic [7:0]       in_byte_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [2:0]       phase_o;
  logic             payload_valid_o;
  logic [7:0]       payload_byte_o;
  logic [7:0]       payload_index_o;
  logic             frame_done_o;
  logic             crc_ok_o;
  logic [8:0]       frame_length_o;
  logic [7:0]       frame_opcode_o;
  logic [7:0]       frame_source_o;
  logic [7:0]       frame_dest_o;
  logic             timed_out_o;

  frame_deframer_crc16_check u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_i       (command_i),
    .in_byte_i       (in_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .phase_o         (phase_o),
    .payload_valid_o (payload_valid_o),
    .payload_byte_o  (payload_byte_o),
    .payload_index_o (payload_index_o),
    .frame_done_o    (frame_done_o),
    .crc_ok_o        (crc_ok_o),
    .frame_length_o  (frame_length_o),
    .frame_opcode_o  (frame_opcode_o),
    .frame_source_o  (frame_source_o),
    .frame_dest_o    (frame_dest_o),
    .timed_out_o     (timed_out_o)
  );

  // register copies
  logic [15:0] cfg_preamble = PreambleRst;
  logic [8:0]  cfg_max_len  = MaxLenRst;
  logic [15:0] cfg_timeout  = TimeoutRst;

  // parser copy
  phase_e      fr_phase  = PH_HUNT;
  logic        fr_half   = 1'b0;
  logic [15:0] fr_len    = '0;
  logic [7:0]  fr_opc    = '0;
  logic [7:0]  fr_src    = '0;
  logic [7:0]  fr_dst    = '0;
  logic [15:0] fr_rx_crc = '0;
  logic [15:0] fr_crc    = CrcInit;
  logic [8:0]  fr_count  = '0;
  logic [16:0] fr_ticks  = '0;

  result_t     parse_results_q[$];
  int unsigned mismatch_count = 0;
  int unsigned sent_count     = 0;
  int unsigned quiet_cycles   = 0;
  bit          no_idle        = 1'b0;
  int unsigned tick_odds      = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] crc16_step(input logic [15:0] c, input logic [7:0] d);
    logic [15:0] v;
    int          k;
    v = c ^ {d, 8'h00};
    for (k = 0; k < 8; k++) v = v[15] ? ({v[14:0], 1'b0} ^ CcittPoly) : {v[14:0], 1'b0};
    return v;
  endfunction

  function automatic result_t parse_item(input logic cmd, input logic [7:0] b);
    result_t r;
    logic    tmo;
    r   = '0;
    tmo = 1'b0;
    if (cmd == CmdTick) begin
      if (fr_ticks != TickMax) fr_ticks = fr_ticks + 1'b1;
      r.phase = fr_phase;
      return r;
    end
    case (fr_phase)
      PH_HUNT: begin
        fr_ticks = '0;
        if (!fr_half) begin
          if (b == cfg_preamble[7:0]) begin
            fr_crc  = crc16_step(CrcInit, b);
            fr_half = 1'b1;
          end
        end else begin
          // a miss here drops the byte, it is not tried as a first byte
          fr_half = 1'b0;
          if (b == cfg_preamble[15:8]) begin
            fr_crc   = crc16_step(fr_crc, b);
            fr_count = '0;
            fr_phase = PH_LEN;
          end
        end
      end
      PH_LEN: begin
        fr_crc = crc16_step(fr_crc, b);
        if (!fr_half) begin
          fr_len  = {8'h00, b};
          fr_half = 1'b1;
        end else begin
          fr_half     = 1'b0;
          fr_len[15:8] = b;
          if (fr_len <= cfg_max_len && fr_len <= MaxPayload) fr_phase = PH_OPC;
          else fr_phase = PH_HUNT;
        end
      end
      PH_OPC: begin
        fr_crc   = crc16_step(fr_crc, b);
        fr_opc   = b;
        fr_phase = PH_SRC;
      end
      PH_SRC: begin
        fr_crc   = crc16_step(fr_crc, b);
        fr_src   = b;
        fr_phase = PH_DST;
      end
      PH_DST: begin
        fr_crc   = crc16_step(fr_crc, b);
        fr_dst   = b;
        fr_phase = PH_CRC;
      end
      PH_CRC: begin
        // CRC field is covered as zeros
        fr_crc = crc16_step(fr_crc, 8'h00);
        if (!fr_half) begin
          fr_rx_crc = {8'h00, b};
          fr_half   = 1'b1;
        end else begin
          fr_half         = 1'b0;
          fr_rx_crc[15:8] = b;
          fr_phase        = (fr_len == 16'd0) ? PH_READY : PH_DATA;
        end
      end
      PH_DATA: begin
        fr_crc          = crc16_step(fr_crc, b);
        r.payload_valid = 1'b1;
        r.payload_byte  = b;
        r.payload_index = fr_count[7:0];
        fr_count        = fr_count + 1'b1;
        if (fr_count >= fr_len) begin
          fr_count = '0;
          fr_phase = PH_READY;
        end
      end
      default: begin
        fr_phase = PH_HUNT;
        fr_half  = 1'b0;
      end
    endcase
    if (fr_ticks > cfg_timeout) begin
      fr_phase = PH_HUNT;
      fr_half  = 1'b0;
      tmo      = 1'b1;
    end
    r.phase = fr_phase;
    if (fr_phase == PH_READY) begin
      r.frame_done   = 1'b1;
      r.crc_ok       = (fr_rx_crc == fr_crc);
      r.frame_length = fr_len[8:0];
      r.frame_opcode = fr_opc;
      r.frame_source = fr_src;
      r.frame_dest   = fr_dst;
      fr_phase       = PH_HUNT;
      fr_half        = 1'b0;
    end
    r.timed_out = tmo;
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    if (no_idle || $urandom_range(0, 1) == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task automatic send_item(input logic cmd, input logic [7:0] b);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    parse_results_q.push_back(parse_item(cmd, b));
    sent_count++;
  endtask

  task automatic maybe_ticks();
    if ($urandom_range(0, 99) < tick_odds)
      repeat ($urandom_range(1, 3)) send_item(CmdTick, 8'($urandom));
  endtask

  // sends the first 'cut' bytes of a frame built for the current preamble
  task automatic send_frame(input logic [15:0] len, input logic [7:0] opc,
                            input logic [7:0] src, input logic [7:0] dst,
                            input bit bad_crc, input int unsigned cut);
    logic [7:0]  fb[$];
    logic [7:0]  pl[$];
    logic [15:0] c;
    int unsigned n;
    int unsigned i;
    fb = '{cfg_preamble[7:0], cfg_preamble[15:8], len[7:0], len[15:8], opc, src, dst};
    c  = CrcInit;
    foreach (fb[j]) c = crc16_step(c, fb[j]);
    c = crc16_step(c, 8'h00);
    c = crc16_step(c, 8'h00);
    n = (len > MaxPayload) ? $urandom_range(0, 4) : len;
    repeat (n) pl.push_back(8'($urandom));
    foreach (pl[j]) c = crc16_step(c, pl[j]);
    if (bad_crc) c = c ^ 16'($urandom_range(1, 16'hFFFF));
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    foreach (pl[j]) fb.push_back(pl[j]);
    for (i = 0; i < fb.size() && i < cut; i++) begin
      maybe_ticks();
      send_item(CmdByte, fb[i]);
    end
  endtask

  // sender goes quiet until every result has come back
  task automatic await_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (parse_results_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [15:0] val);
    await_results();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, val};
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegPreamble: cfg_preamble = val;
      RegMaxLen:   cfg_max_len  = val[8:0];
      RegTimeout:  cfg_timeout  = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] pre, input logic [8:0] max_len,
                            input logic [15:0] tmo);
    cfg_write(RegPreamble, pre);
    cfg_write(RegMaxLen, {7'h00, max_len});
    cfg_write(RegTimeout, tmo);
  endtask

  function automatic logic [15:0] rand_len();
    int unsigned pick;
    int unsigned top;
    pick = $urandom_range(0, 99);
    top  = (cfg_max_len < 8) ? cfg_max_len : 8;
    if (pick < 78) return 16'($urandom_range(0, top));
    if (pick < 80) return 16'(cfg_max_len);
    if (pick < 90) return 16'($urandom_range(cfg_max_len + 1, 300));
    return 16'($urandom);
  endfunction

  // ---- tests ----

  task automatic test_reset_config();
    // preamble 00 00, limits at their reset values
    send_frame(16'd0, 8'h00, 8'hFF, 8'h00, 1'b0, FullFrame);
  endtask

  task automatic test_preamble_restart();
    cfg_write(RegPreamble, 16'hC35A);
    send_item(CmdByte, 8'h5A);
    send_item(CmdByte, 8'h5A);
    send_item(CmdByte, 8'hC3);
    send_item(CmdTick, 8'hFF);
    send_frame(16'd0, 8'hFF, 8'h00, 8'hFF, 1'b1, FullFrame);
  endtask

  task automatic test_oversize();
    cfg_write(RegMaxLen, 16'd0);
    send_frame(16'd1, 8'h11, 8'h22, 8'h33, 1'b0, 4);
    cfg_write(RegMaxLen, 16'd256);
    send_frame(16'd257, 8'h11, 8'h22, 8'h33, 1'b0, 4);
    send_frame(16'hFF00, 8'h11, 8'h22, 8'h33, 1'b0, 4);
  endtask

  task automatic test_timeout();
    cfg_write(RegTimeout, 16'd0);
    // ticks while hunting are cleared by the preamble bytes
    send_item(CmdTick, 8'h00);
    send_item(CmdTick, 8'h00);
    send_frame(16'd0, 8'h00, 8'h00, 8'h00, 1'b0, FullFrame);
    // payload byte still reported, completion overridden
    send_frame(16'd1, 8'h81, 8'h42, 8'h18, 1'b0, 9);
    send_item(CmdTick, 8'h00);
    send_item(CmdByte, 8'hA7);
    send_frame(16'd3, 8'h81, 8'h42, 8'h18, 1'b0, 2);
    send_item(CmdTick, 8'h00);
    send_item(CmdByte, 8'h03);
  endtask

  task automatic test_tick_count();
    cfg_write(RegTimeout, 16'd40);
    no_idle = 1'b1;
    send_frame(16'd0, 8'h00, 8'h00, 8'h00, 1'b0, 2);
    // a count equal to the limit keeps the frame, one more drops it
    repeat (40) send_item(CmdTick, 8'h00);
    send_item(CmdByte, 8'h00);
    send_item(CmdTick, 8'h00);
    send_item(CmdByte, 8'h00);
    no_idle = 1'b0;
  endtask

  task automatic run_round(input int unsigned items, input bit pause_midway);
    int unsigned stop_at;
    int unsigned pick;
    bit          paused;
    stop_at = sent_count + items;
    paused  = 1'b0;
    while (sent_count < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        send_frame(rand_len(), 8'($urandom), 8'($urandom), 8'($urandom),
                   $urandom_range(0, 3) == 0, FullFrame);
      end else if (pick == 6) begin
        send_frame(rand_len(), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0,
                   $urandom_range(1, 8));
      end else if (pick == 7) begin
        send_item(CmdByte, cfg_preamble[7:0]);
        send_item(CmdByte, ~cfg_preamble[15:8]);
      end else begin
        repeat ($urandom_range(1, 4)) send_item(1'($urandom_range(0, 1)), 8'($urandom));
      end
      if (pause_midway && !paused && sent_count >= stop_at - items / 2) begin
        await_results();
        paused = 1'b1;
      end
    end
  endtask

  task automatic test_random();
    tick_odds = 20;
    set_config(16'($urandom), 9'd256, 16'($urandom_range(4, 20)));
    run_round(RoundItems, 1'b1);
    tick_odds = 10;
    no_idle   = 1'b1;
    set_config(16'hFFFF, 9'd0, 16'd0);
    run_round(RoundItems, 1'b0);
    no_idle   = 1'b0;
    tick_odds = 25;
    set_config(16'h0000, 9'($urandom_range(1, 255)), 16'($urandom_range(0, 8)));
    run_round(RoundItems, 1'b0);
    tick_odds = 30;
    set_config(16'($urandom), 9'd256, 16'hFFFF);
    run_round(RoundItems, 1'b1);
    tick_odds = 20;
    set_config(16'($urandom), 9'($urandom_range(0, 256)), 16'($urandom_range(0, 30)));
    run_round(RoundItems, 1'b0);
  endtask

  // ---- stimulus ----

  initial begin
    rst_ni     = 1'b0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    in_valid_i = 1'b0;
    command_i  = CmdByte;
    in_byte_i  = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_config();
    test_preamble_restart();
    test_oversize();
    test_timeout();
    test_tick_count();
    test_random();
    await_results();
    if (mismatch_count == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // ---- result side ----

  initial begin : out_side
    int unsigned stall;
    out_ready_i = 1'b0;
    wait (rst_ni);
    forever begin
      stall = draw_gap();
      @(negedge clk_i);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic note_field(input string name, input logic [8:0] want_v,
                            input logic [8:0] got_v);
    if (want_v !== got_v) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want_v, got_v);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (parse_results_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result transfer with none pending, phase %0d", $time, phase_o);
      end else begin
        want = parse_results_q.pop_front();
        note_field("phase",         want.phase,         phase_o);
        note_field("payload_valid", want.payload_valid, payload_valid_o);
        note_field("payload_byte",  want.payload_byte,  payload_byte_o);
        note_field("payload_index", want.payload_index, payload_index_o);
        note_field("frame_done",    want.frame_done,    frame_done_o);
        note_field("crc_ok",        want.crc_ok,        crc_ok_o);
        note_field("frame_length",  want.frame_length,  frame_length_o);
        note_field("frame_opcode",  want.frame_opcode,  frame_opcode_o);
        note_field("frame_source",  want.frame_source,  frame_source_o);
        note_field("frame_dest",    want.frame_dest,    frame_dest_o);
        note_field("timed_out",     want.timed_out,     timed_out_o);
      end
    end
  end

  // hang guard: cycles without any transfer on either channel
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule
